/* hw/rtl/beat_sync_tempo_rate_adjuster_unit_macros.svh */
// Assertion macros shared by the RTL files.
`ifndef BEAT_SYNC_TEMPO_RATE_ADJUSTER_UNIT_MACROS_SVH
`define BEAT_SYNC_TEMPO_RATE_ADJUSTER_UNIT_MACROS_SVH
`ifndef SYNTHESIS
`define BSTR_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define BSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define BSTR_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define BSTR_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hw/rtl/bstra_pkg.sv */
`default_nettype none
package bstra_pkg;

	// Register indexes of the configuration port.
	localparam logic [2:0] REG_BEAT_MULT  = 3'd0;
	localparam logic [2:0] REG_INTRO      = 3'd1;
	localparam logic [2:0] REG_LOOP_BEATS = 3'd2;
	localparam logic [2:0] REG_LOOP_START = 3'd3;
	localparam logic [2:0] REG_LOOP_END   = 3'd4;
	localparam logic [2:0] REG_SRATE      = 3'd5;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_RESTART = 1'b1;

	localparam logic [17:0] RATE_ONE = 18'd65536;
	localparam logic [31:0] LEAD_SAMPLES = 32'd500;
	localparam logic [6:0]  SECS_PER_MIN = 7'd60;

	// Width of the shared shift-subtract divider.
	localparam int DIV_W = 64;
	localparam int DIV_CNT_W = 7;

	// Input and output words.
	typedef struct packed {
		logic        operation;
		logic        stream_active;
		logic [23:0] tempo;
		logic [31:0] current_sample;
		logic [31:0] stream_loop_count;
	} in_word_t;

	typedef struct packed {
		logic [17:0] rate;
		logic        beat_wrapped;
		logic        stream_wrapped;
	} out_word_t;

	// Datapath commands from the controller.
	typedef struct packed {
		logic load;      // capture input word, update tracking state
		logic mul_k;     // step: K partial products
		logic form_n;    // step: numerator
		logic div_start; // start a division
		logic sq;        // square the quotient
		logic recip;     // set up reciprocal division
		logic finish;    // write the result register
	} dp_cmd_t;

	typedef struct packed {
		logic div_busy;
	} dp_status_t;

endpackage
`default_nettype wire

/* hw/rtl/bstra_stream_if.sv */
`default_nettype none
interface bstra_stream_if #(
	parameter int W = 1
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* hw/rtl/bstra_divider.sv */
`default_nettype none
`include "beat_sync_tempo_rate_adjuster_unit_macros.svh"
// Restoring divider, one quotient bit per cycle.
module bstra_divider (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       start,
	input  wire logic [bstra_pkg::DIV_W-1:0] dividend,
	input  wire logic [bstra_pkg::DIV_W-1:0] divisor,
	output logic                            busy,
	output logic [bstra_pkg::DIV_W-1:0]      quotient
);
	logic [bstra_pkg::DIV_W-1:0]   rem_q;
	logic [bstra_pkg::DIV_W-1:0]   quo_q;
	logic [bstra_pkg::DIV_W-1:0]   dvs_q;
	logic [bstra_pkg::DIV_CNT_W-1:0] cnt_q;
	logic                          busy_q;
	logic [bstra_pkg::DIV_W:0]     trial;

	assign trial = {rem_q, quo_q[bstra_pkg::DIV_W-1]};

	// Shift one dividend bit into the remainder and subtract when it fits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= bstra_pkg::DIV_CNT_W'(bstra_pkg::DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == bstra_pkg::DIV_CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= bstra_pkg::DIV_W'(trial - {1'b0, dvs_q});
				quo_q <= {quo_q[bstra_pkg::DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial[bstra_pkg::DIV_W-1:0];
				quo_q <= {quo_q[bstra_pkg::DIV_W-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

	`BSTR_ASSERT_IMPL(a_cnt_busy, clk, arst_n, busy_q, cnt_q != '0)
	`BSTR_ASSERT_NEXT(a_start_busy, clk, arst_n, start, busy_q)
	`BSTR_ASSERT_IMPL(a_idle_cnt, clk, arst_n, !busy_q, cnt_q == '0)
endmodule
`default_nettype wire

/* hw/rtl/bstra_datapath.sv */
`default_nettype none
`include "beat_sync_tempo_rate_adjuster_unit_macros.svh"
// Tracking state, error arithmetic and result register.
module bstra_datapath (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bstra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bstra_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire bstra_pkg::in_word_t             in_word,
	input  wire bstra_pkg::dp_cmd_t              cmd,
	output bstra_pkg::dp_status_t                status,
	output bstra_pkg::out_word_t                 out_word
);
	// Configuration registers.
	logic [15:0] beat_mult_q, intro_q, loop_beats_q;
	logic [31:0] loop_start_q, loop_end_q;
	logic [17:0] srate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beat_mult_q  <= 16'd256;
			intro_q      <= '0;
			loop_beats_q <= '0;
			loop_start_q <= '0;
			loop_end_q   <= '0;
			srate_q      <= 18'd32000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				bstra_pkg::REG_BEAT_MULT:  beat_mult_q  <= cfg_data[15:0];
				bstra_pkg::REG_INTRO:      intro_q      <= cfg_data[15:0];
				bstra_pkg::REG_LOOP_BEATS: loop_beats_q <= cfg_data[15:0];
				bstra_pkg::REG_LOOP_START: loop_start_q <= cfg_data;
				bstra_pkg::REG_LOOP_END:   loop_end_q   <= cfg_data;
				bstra_pkg::REG_SRATE:      srate_q      <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// Tracking state.
	logic [31:0] last_cnt_q, beat_idx_q;
	logic        beat_pend_q, stream_pend_q;

	logic        stream_new, beat_new;
	logic [32:0] wrap_lim;
	logic [31:0] idx_eff, loop_len;
	logic        bp_next, sp_next;

	assign stream_new = in_word.stream_loop_count != last_cnt_q;
	assign wrap_lim   = {17'd0, intro_q} + {17'd0, loop_beats_q};
	assign beat_new   = (loop_beats_q != '0) && ({1'b0, beat_idx_q} >= wrap_lim);
	assign idx_eff    = beat_new ? {16'd0, intro_q} : beat_idx_q;
	assign loop_len   = loop_end_q - loop_start_q;
	assign bp_next    = beat_pend_q | beat_new;
	assign sp_next    = stream_pend_q | stream_new;

	logic tick_live;
	assign tick_live = (in_word.operation == bstra_pkg::OP_TICK) && in_word.stream_active;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_cnt_q    <= '0;
			beat_idx_q    <= '0;
			beat_pend_q   <= 1'b0;
			stream_pend_q <= 1'b0;
		end else if (cmd.load) begin
			if (in_word.operation == bstra_pkg::OP_RESTART) begin
				last_cnt_q    <= '0;
				beat_idx_q    <= '0;
				beat_pend_q   <= 1'b0;
				stream_pend_q <= 1'b0;
			end else if (in_word.stream_active) begin
				last_cnt_q    <= in_word.stream_loop_count;
				beat_idx_q    <= idx_eff + 32'd1;
				beat_pend_q   <= bp_next & ~(bp_next & sp_next);
				stream_pend_q <= sp_next & ~(bp_next & sp_next);
			end
		end
	end

	// Shifted position less the lead, signed 35 bits.
	logic signed [34:0] pos_adj;
	always_comb begin
		pos_adj = $signed({3'd0, in_word.current_sample})
			- $signed({3'd0, bstra_pkg::LEAD_SAMPLES});
		if (loop_len != '0) begin
			if (beat_new && !stream_new && !stream_pend_q) begin
				pos_adj = pos_adj - $signed({3'd0, loop_len});
			end else if (!beat_new && stream_new && !beat_pend_q) begin
				pos_adj = pos_adj + $signed({3'd0, loop_len});
			end
		end
	end

	// Work registers.
	logic signed [34:0] pos_q;
	logic [23:0] tempo_q;
	logic [31:0] idx_q;
	logic        bw_q, sw_q, live_q;
	logic [23:0] sk_q;    // 60 * sample_rate
	logic [39:0] k_q;     // K
	logic [71:0] bk_q;    // beat index times K
	logic signed [59:0] a_q;
	logic        early_q, trivial_q, need_q;
	logic [21:0] q_q;
	logic [16:0] sq_q;
	logic [1:0]  phase_q;
	logic [63:0] dvd_q, dvs_q;

	// Partial products: 60 * rate, then K, then beat*K and position*tempo.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			pos_q   <= pos_adj;
			tempo_q <= in_word.tempo;
			idx_q   <= idx_eff;
			bw_q    <= beat_new & tick_live;
			sw_q    <= stream_new & tick_live;
			live_q  <= tick_live;
			sk_q    <= 24'(srate_q * bstra_pkg::SECS_PER_MIN);
			phase_q <= 2'd0;
		end else if (cmd.mul_k) begin
			phase_q <= phase_q + 2'd1;
			unique case (phase_q)
				2'd0: k_q <= 40'(sk_q * beat_mult_q);
				2'd1: bk_q <= 72'(idx_q * k_q);
				2'd2: a_q <= 60'(pos_q * $signed({1'b0, tempo_q}));
				default: ;
			endcase
		end
	end

	// Numerator, clamping and division setup.
	logic signed [73:0] n_full;
	logic [73:0] n_mag;
	assign n_full = 74'(a_q) - $signed({2'b0, bk_q});
	assign n_mag  = n_full[73] ? 74'(-n_full) : n_full;

	// Square of the error fraction, and the early-side divisor.
	logic [43:0] q_sqr;
	logic [16:0] sq_eff;
	logic [17:0] d_sum;
	assign q_sqr  = {22'd0, q_q} * {22'd0, q_q};
	assign sq_eff = need_q ? sq_q : 17'd65536;
	assign d_sum  = 18'd65536 + {1'b0, sq_eff};

	always_ff @(posedge clk) begin
		if (cmd.form_n) begin
			trivial_q <= (k_q == '0) || (tempo_q == '0) || !live_q;
			if (bk_q > 72'h3FFF_FFFF_FFFF_FFFF) begin
				early_q <= 1'b1;
				need_q  <= 1'b0;
			end else begin
				early_q <= n_full[73];
				need_q  <= n_mag < {34'd0, k_q};
			end
			dvd_q <= {n_mag[43:0], 20'd0};
			dvs_q <= {24'd0, k_q};
		end else if (cmd.sq) begin
			sq_q <= (q_sqr[43:24] > 20'd65536) ? 17'd65536 : q_sqr[40:24];
		end else if (cmd.recip) begin
			dvd_q <= 64'h1_0000_0000 + {47'd0, d_sum[17:1]};
			dvs_q <= {46'd0, d_sum};
		end
	end

	logic [63:0] quo;
	logic        dbusy;
	bstra_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dvd_q),
		.divisor  (dvs_q),
		.busy     (dbusy),
		.quotient (quo)
	);

	always_ff @(posedge clk) begin
		if (cmd.sq == 1'b0 && !dbusy && !cmd.recip && !cmd.finish) begin
			q_q <= quo[21:0];
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_word.beat_wrapped   <= bw_q;
			out_word.stream_wrapped <= sw_q;
			if (trivial_q) begin
				out_word.rate <= bstra_pkg::RATE_ONE;
			end else if (!early_q) begin
				out_word.rate <= d_sum;
			end else begin
				out_word.rate <= quo[17:0];
			end
		end
	end

	assign status.div_busy = dbusy;

	`BSTR_ASSERT_NEXT(a_restart_clr, clk, arst_n,
		cmd.load && in_word.operation == bstra_pkg::OP_RESTART, beat_idx_q == '0)
	`BSTR_ASSERT_IMPL(a_pend_pair, clk, arst_n, 1'b1, !(beat_pend_q && stream_pend_q))
	`BSTR_ASSERT_NEXT(a_idle_hold, clk, arst_n,
		cmd.load && !in_word.stream_active && in_word.operation == bstra_pkg::OP_TICK,
		$stable(beat_idx_q))
endmodule
`default_nettype wire

/* hw/rtl/bstra_ctrl.sv */
`default_nettype none
`include "beat_sync_tempo_rate_adjuster_unit_macros.svh"
// Sequencer for one word: multiply, form error, divide, square, reciprocal.
module bstra_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	input  wire bstra_pkg::dp_status_t status,
	output bstra_pkg::dp_cmd_t         cmd
);
	typedef enum logic [3:0] {
		S_IDLE, S_MUL0, S_MUL1, S_MUL2, S_NUM, S_DIVQ, S_WAITQ, S_SQ,
		S_RECIP, S_DIVR, S_WAITR, S_FIN
	} state_t;

	state_t state_q;
	logic   started_q;

	// Result register may be taken while the next word is accepted.
	logic   out_full_q;
	assign out_valid = out_full_q;
	assign in_ready  = (state_q == S_IDLE);

	// The result register is written only once the previous word has left it.
	always_comb begin
		cmd = '0;
		cmd.load      = in_valid && in_ready;
		cmd.mul_k     = (state_q == S_MUL0) || (state_q == S_MUL1) || (state_q == S_MUL2);
		cmd.form_n    = (state_q == S_NUM);
		cmd.div_start = (state_q == S_DIVQ) || (state_q == S_DIVR);
		cmd.sq        = (state_q == S_SQ);
		cmd.recip     = (state_q == S_RECIP);
		cmd.finish    = (state_q == S_FIN) && (!out_full_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			out_full_q <= 1'b0;
			started_q  <= 1'b0;
		end else begin
			if (cmd.finish) begin
				out_full_q <= 1'b1;
			end else if (out_valid && out_ready) begin
				out_full_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: if (in_valid) state_q <= S_MUL0;
				S_MUL0: state_q <= S_MUL1;
				S_MUL1: state_q <= S_MUL2;
				S_MUL2: state_q <= S_NUM;
				S_NUM: state_q <= S_DIVQ;
				S_DIVQ: begin
					started_q <= 1'b1;
					state_q <= S_WAITQ;
				end
				S_WAITQ: begin
					started_q <= 1'b0;
					if (!status.div_busy && !started_q) state_q <= S_SQ;
				end
				S_SQ: state_q <= S_RECIP;
				S_RECIP: state_q <= S_DIVR;
				S_DIVR: begin
					started_q <= 1'b1;
					state_q <= S_WAITR;
				end
				S_WAITR: begin
					started_q <= 1'b0;
					if (!status.div_busy && !started_q) state_q <= S_FIN;
				end
				S_FIN: if (cmd.finish) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`BSTR_ASSERT_IMPL(a_load_idle, clk, arst_n, cmd.load, state_q == S_IDLE)
	`BSTR_ASSERT_NEXT(a_fin_out, clk, arst_n, cmd.finish, out_valid && state_q == S_IDLE)
	`BSTR_ASSERT_IMPL(a_cmd_excl, clk, arst_n, 1'b1,
		$onehot0({cmd.load, cmd.form_n, cmd.sq, cmd.recip, cmd.finish}))
endmodule
`default_nettype wire

/* hw/rtl/beat_sync_tempo_rate_adjuster_unit.sv */
`default_nettype none
// Beat-synchronized tempo rate adjuster. Each input word (a beat tick or a
// restart) yields one result word with a Q2.16 playback rate and two wrap
// flags. A word passes through three multiply steps and a numerator step,
// then two passes through one shared 64-step shift-subtract divider (the
// error fraction and the early-side reciprocal), with squaring and reciprocal
// setup steps between them. A word is taken only while the sequencer is
// idle; the sequencer holds its last step while the previous result is
// still waiting to be taken.
module beat_sync_tempo_rate_adjuster_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [bstra_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bstra_pkg::CFG_DATA_W-1:0] cfg_data,
	bstra_stream_if.sink                          in_ch,
	bstra_stream_if.source                        out_ch
);
	bstra_pkg::dp_cmd_t    cmd;
	bstra_pkg::dp_status_t status;
	bstra_pkg::in_word_t   in_word;
	bstra_pkg::out_word_t  out_word;

	assign in_word = bstra_pkg::in_word_t'(in_ch.data);
	assign out_ch.data = $bits(out_ch.data)'(out_word);

	bstra_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.status    (status),
		.cmd       (cmd)
	);

	bstra_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_word   (in_word),
		.cmd       (cmd),
		.status    (status),
		.out_word  (out_word)
	);
endmodule
`default_nettype wire

/* tb/tb_beat_sync_tempo_rate_adjuster_unit.sv */
`default_nettype none
module tb_beat_sync_tempo_rate_adjuster_unit;
	import bstra_pkg::*;

	localparam longint CYCLE_LIMIT = 3000000;
	localparam int SETTLE_CYCLES = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	bstra_stream_if #(.W($bits(in_word_t))) in_ch ();
	bstra_stream_if #(.W($bits(out_word_t))) out_ch ();

	beat_sync_tempo_rate_adjuster_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	// Shadow copy of the registers and of the tracking state.
	logic [15:0] sh_bmult = 16'd256;
	logic [15:0] sh_intro = 16'd0;
	logic [15:0] sh_loops = 16'd0;
	logic [31:0] sh_loop_start = 32'd0;
	logic [31:0] sh_loop_end = 32'd0;
	logic [17:0] sh_srate = 18'd32000;
	logic [31:0] trk_last_count = 32'd0;
	logic [31:0] trk_beat = 32'd0;
	logic trk_beat_pend = 1'b0;
	logic trk_stream_pend = 1'b0;

	in_word_t pend_words[$];
	out_word_t rate_expect[$];
	int send_idle = 25;
	int recv_idle = 86;
	int errors = 0;
	longint cycles = 0;

	// Stimulus-side view of where the song should be.
	longint gen_beat = 0;
	logic [31:0] gen_count = 32'd0;
	bit gen_late = 1'b0;
	bit gen_skip = 1'b0;

	initial begin
		forever #10 clk = ~clk;
	end

	// Rate for a shifted position, tempo and beat, in Q2.16.
	function automatic logic [17:0] rate_for(longint pos, logic [23:0] tempo, logic [31:0] beat);
		logic [63:0] k;
		logic [63:0] mag;
		logic [63:0] q;
		logic [63:0] d;
		logic [63:0] sq;
		longint a;
		longint b;
		longint n;
		bit early;
		k = 64'd60 * {46'd0, sh_srate} * {48'd0, sh_bmult};
		if (k == 64'd0 || tempo == 24'd0)
			return RATE_ONE;
		if ({32'd0, beat} > ((64'd1 << 62) - 64'd1) / k) begin
			early = 1'b1;
			sq = 64'd65536;
		end else begin
			a = (pos - 500) * longint'({40'd0, tempo});
			b = longint'({32'd0, beat} * k);
			n = a - b;
			early = n < 0;
			mag = early ? 64'(-n) : 64'(n);
			if (mag >= k) begin
				sq = 64'd65536;
			end else begin
				q = (mag << 20) / k;
				sq = (q * q) >> 24;
				if (sq > 64'd65536)
					sq = 64'd65536;
			end
		end
		if (!early)
			return 18'(64'd65536 + sq);
		d = 64'd65536 + sq;
		return 18'(((64'd1 << 32) + d / 2) / d);
	endfunction

	// Advance the tracking state by one accepted word and queue its result.
	function automatic void predict_word(in_word_t w);
		out_word_t r;
		logic [31:0] loop_len;
		longint pos;
		bit stream_new;
		bit beat_new;
		r.rate = RATE_ONE;
		r.beat_wrapped = 1'b0;
		r.stream_wrapped = 1'b0;
		stream_new = 1'b0;
		beat_new = 1'b0;
		if (w.operation == OP_RESTART) begin
			trk_last_count = '0;
			trk_beat = '0;
			trk_beat_pend = 1'b0;
			trk_stream_pend = 1'b0;
		end else if (w.stream_active) begin
			if (w.stream_loop_count != trk_last_count) begin
				stream_new = 1'b1;
				trk_last_count = w.stream_loop_count;
			end
			if (sh_loops != 16'd0 && {32'd0, trk_beat} >= {48'd0, sh_intro} + {48'd0, sh_loops})
				begin
				trk_beat = {16'd0, sh_intro};
				beat_new = 1'b1;
			end
			loop_len = sh_loop_end - sh_loop_start;
			pos = longint'({32'd0, w.current_sample});
			if (loop_len != 32'd0) begin
				if (beat_new && !stream_new && !trk_stream_pend)
					pos = pos - longint'({32'd0, loop_len});
				else if (!beat_new && stream_new && !trk_beat_pend)
					pos = pos + longint'({32'd0, loop_len});
			end
			r.rate = rate_for(pos, w.tempo, trk_beat);
			if (beat_new)
				trk_beat_pend = 1'b1;
			if (stream_new)
				trk_stream_pend = 1'b1;
			if (trk_beat_pend && trk_stream_pend) begin
				trk_beat_pend = 1'b0;
				trk_stream_pend = 1'b0;
			end
			trk_beat = trk_beat + 32'd1;
			r.beat_wrapped = beat_new;
			r.stream_wrapped = stream_new;
		end
		rate_expect.push_back(r);
	endfunction

	// Driver: presents the oldest pending word, idling at random.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				predict_word(pend_words.pop_front());
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (pend_words.size() > 0 && $urandom_range(99) >= send_idle) begin
					in_ch.valid <= 1'b1;
					in_ch.data <= pend_words[0];
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result word against the oldest expectation.
	always @(posedge clk or negedge arst_n) begin
		out_word_t got;
		out_word_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_word_t'(out_ch.data);
				if (rate_expect.size() == 0) begin
					$error("result word with nothing expected: %h", got);
					errors++;
				end else begin
					want = rate_expect.pop_front();
					if (got.rate !== want.rate) begin
						$error("rate: expected %0d, actual %0d", want.rate, got.rate);
						errors++;
					end
					if (got.beat_wrapped !== want.beat_wrapped) begin
						$error("beat_wrapped: expected %0d, actual %0d", want.beat_wrapped,
							got.beat_wrapped);
						errors++;
					end
					if (got.stream_wrapped !== want.stream_wrapped) begin
						$error("stream_wrapped: expected %0d, actual %0d", want.stream_wrapped,
							got.stream_wrapped);
						errors++;
					end
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle);
		end
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL beat_sync_tempo_rate_adjuster_unit");
			$finish;
		end
	end

	// One register write, mirrored into the shadow copy.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_BEAT_MULT: sh_bmult = val[15:0];
			REG_INTRO: sh_intro = val[15:0];
			REG_LOOP_BEATS: sh_loops = val[15:0];
			REG_LOOP_START: sh_loop_start = val;
			REG_LOOP_END: sh_loop_end = val;
			REG_SRATE: sh_srate = val[17:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait until every word is in and every result is out, then let the block settle.
	task automatic drain();
		while (pend_words.size() > 0 || rate_expect.size() > 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic push_word(bit op, bit act, logic [23:0] tempo, logic [31:0] cur,
		logic [31:0] cnt);
		in_word_t w;
		w.operation = op;
		w.stream_active = act;
		w.tempo = tempo;
		w.current_sample = cur;
		w.stream_loop_count = cnt;
		pend_words.push_back(w);
	endtask

	// Mostly in-time beat ticks around the ideal position, with some noise.
	task automatic fill_song(int count, logic [23:0] tempo_nom);
		longint spb;
		longint span;
		longint cur;
		int r;
		spb = (60 * longint'(sh_srate) * longint'(sh_bmult)) / longint'(tempo_nom);
		span = spb / 3;
		if (span > 64'sd1000000000)
			span = 1000000000;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 3) begin
				push_word(OP_RESTART, $urandom_range(1), $urandom, $urandom, $urandom);
				gen_beat = 0;
				gen_count = 0;
				gen_late = 0;
				gen_skip = 0;
			end else if (r < 8) begin
				push_word(OP_TICK, 1'b0, $urandom, $urandom, $urandom);
			end else if (r < 15) begin
				gen_count = $urandom;
				push_word(OP_TICK, 1'b1, $urandom, $urandom, gen_count);
				gen_beat++;
			end else begin
				// Stream wrap may land with the beat wrap, a tick late, or a tick early.
				if (sh_loops != 0 && gen_beat >= longint'(sh_intro) + longint'(sh_loops)) begin
					gen_beat = sh_intro;
					if (gen_skip)
						gen_skip = 0;
					else if ($urandom_range(3) == 0)
						gen_late = 1;
					else
						gen_count++;
				end else if (gen_late) begin
					gen_count++;
					gen_late = 0;
				end else if (sh_loops != 0 && !gen_skip &&
					gen_beat + 1 == longint'(sh_intro) + longint'(sh_loops) &&
					$urandom_range(4) == 0) begin
					gen_count++;
					gen_skip = 1;
				end
				cur = 500 + gen_beat * spb + longint'($urandom_range(32'(2 * span))) - span;
				push_word(OP_TICK, 1'b1, ($urandom_range(9) == 0) ? 24'($urandom) : tempo_nom,
					32'(cur), gen_count);
				gen_beat++;
			end
		end
	endtask

	// Sets the loop window to a whole number of beats at the nominal tempo.
	task automatic set_song(logic [15:0] bm, logic [15:0] intro, logic [15:0] loops,
		logic [17:0] sr, logic [23:0] tempo_nom, logic [31:0] start);
		longint spb;
		write_reg(REG_BEAT_MULT, {16'd0, bm});
		write_reg(REG_INTRO, {16'd0, intro});
		write_reg(REG_LOOP_BEATS, {16'd0, loops});
		write_reg(REG_SRATE, {14'd0, sr});
		spb = (60 * longint'(sr) * longint'(bm)) / longint'(tempo_nom);
		write_reg(REG_LOOP_START, start);
		write_reg(REG_LOOP_END, start + 32'(spb * longint'(loops)));
	endtask

	// Main sequence: directed words at reset values, then several register settings.
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_word(OP_RESTART, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_word(OP_TICK, 1'b0, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_word(OP_TICK, 1'b1, 24'd0, 32'd500, 32'd0);
		push_word(OP_TICK, 1'b1, 24'd1, 32'd0, 32'd0);
		push_word(OP_TICK, 1'b1, 24'hFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		push_word(OP_TICK, 1'b1, 24'd30720, 32'd48500, 32'hFFFFFFFF);
		push_word(OP_TICK, 1'b1, 24'd30720, 32'd64400, 32'd1);
		push_word(OP_TICK, 1'b1, 24'd30720, 32'd75000, 32'd1);
		push_word(OP_TICK, 1'b1, 24'd30720, 32'd95000, 32'd1);
		push_word(OP_TICK, 1'b1, 24'd30720, 32'd0, 32'd1);
		push_word(OP_RESTART, 1'b0, 24'd0, 32'd0, 32'd0);
		push_word(OP_TICK, 1'b1, 24'd30720, 32'd500, 32'd0);
		fill_song(100, 24'd30720);
		drain();

		// Short loop with an intro.
		set_song(16'd512, 16'd2, 16'd4, 18'd44100, 24'd23040, $urandom);
		fill_song(120, 24'd23040);
		drain();

		// Receiver fast, sender slow from here on; one-beat loop at the top sample rate.
		send_idle = 86;
		recv_idle = 25;
		set_song(16'd1, 16'd0, 16'd1, 18'd192000, 24'd76800, $urandom);
		fill_song(60, 24'd76800);
		drain();
		fill_song(60, 24'd76800);
		drain();

		// Largest register values but a sample rate of one, plus writes to unused indexes.
		write_reg(3'd6, $urandom);
		write_reg(3'd7, $urandom);
		set_song(16'd65535, 16'd65535, 16'd65535, 18'd1, 24'hFFFFFF, 32'hFFFFFFFF);
		fill_song(110, 24'hFFFFFF);
		drain();

		// No idling at all; zero multiplier first.
		send_idle = 0;
		recv_idle = 0;
		write_reg(REG_BEAT_MULT, 32'd0);
		fill_song(15, 24'd30720);
		drain();
		set_song(16'd384, 16'd3, 16'd5, 18'd48000, 24'd32768, $urandom);
		fill_song(110, 24'd32768);
		drain();
		set_song(16'd256, 16'd0, 16'd2, 18'd32000, 24'd30720, 32'hFFFFFF00);
		fill_song(110, 24'd30720);
		drain();

		if (errors == 0)
			$display("PASS beat_sync_tempo_rate_adjuster_unit");
		else
			$display("FAIL beat_sync_tempo_rate_adjuster_unit");
		$finish;
	end
endmodule
`default_nettype wire

/* filelist.f */
+incdir+hw/rtl
hw/rtl/bstra_pkg.sv
hw/rtl/bstra_stream_if.sv
hw/rtl/bstra_divider.sv
hw/rtl/bstra_datapath.sv
hw/rtl/bstra_ctrl.sv
hw/rtl/beat_sync_tempo_rate_adjuster_unit.sv
tb/tb_beat_sync_tempo_rate_adjuster_unit.sv
